FILE: hw/rtl/double_exponential_smoother_top_assert.svh
// ----------------------------------------------------------------------------
// double_exponential_smoother_top_assert
// assertion macros used by the smoother checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_EXPONENTIAL_SMOOTHER_TOP_ASSERT_SVH
`define DOUBLE_EXPONENTIAL_SMOOTHER_TOP_ASSERT_SVH

// antecedent at one edge implies consequent at the next edge
`define DXS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smoother check failed");

`define DXS_ASSERT_AFTER3(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##2 (cons)) \
    else $error("smoother check failed");

`endif

FILE: hw/rtl/dxs_pkg.sv
// ----------------------------------------------------------------------------
// dxs_pkg
// types, constants and helpers of the double exponential smoother
// ----------------------------------------------------------------------------
package dxs_pkg;

  localparam int GAIN_W   = 17;
  localparam int DATA_W   = 32;
  localparam int OPB_W    = 34;
  localparam int PROD_W   = GAIN_W + 1 + OPB_W;
  localparam int IDX_W    = 2;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_HALF = 17'd32768;

  // register indexes
  localparam logic [IDX_W-1:0] REG_ESTIMATE_GAIN    = 2'd0;
  localparam logic [IDX_W-1:0] REG_TREND_GAIN       = 2'd1;
  localparam logic [IDX_W-1:0] REG_INITIAL_ESTIMATE = 2'd2;
  localparam logic [IDX_W-1:0] REG_INITIAL_TREND    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_GC,
    S_TC,
    S_LEVEL,
    S_DIFF,
    S_MUL_T,
    S_SUM,
    S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_TAKE,
    OP_MUL_G,
    OP_MUL_GC,
    OP_MUL_TC,
    OP_LEVEL,
    OP_DIFF,
    OP_MUL_T,
    OP_SUM,
    OP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic load;
  } dp_status_t;

  // add half, floor shift by 16, clamp to 32 bits
  function automatic logic signed [DATA_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] x
  );
    logic signed [PROD_W-1:0]    r;
    logic signed [PROD_W-17:0]   q;
    logic signed [DATA_W-1:0]    y;
    r = x + PROD_W'(GAIN_HALF);
    q = r[PROD_W-1:16];
    if (q > 36'sh07FFFFFFF) begin
      y = 32'sh7FFFFFFF;
    end else if (q < 36'shF80000000) begin
      y = 32'sh80000000;
    end else begin
      y = q[DATA_W-1:0];
    end
    return y;
  endfunction

endpackage

FILE: hw/rtl/dxs_ctrl.sv
// ----------------------------------------------------------------------------
// dxs_ctrl
// sequencer of the smoother: steps the shared multiplier, owns the handshakes
// ----------------------------------------------------------------------------
module dxs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dxs_pkg::dp_status_t status,
  output dxs_pkg::dp_cmd_t    cmd
);
  import dxs_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   out_valid_next;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_START;
      S_START: state_next = status.load ? S_FIN : S_GC;
      S_GC:    state_next = S_TC;
      S_TC:    state_next = S_LEVEL;
      S_LEVEL: state_next = S_DIFF;
      S_DIFF:  state_next = S_MUL_T;
      S_MUL_T: state_next = S_SUM;
      S_SUM:   state_next = S_FIN;
      S_FIN:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd.op         = OP_NOP;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_TAKE;
      end
      S_START: cmd.op = status.load ? OP_NOP : OP_MUL_G;
      S_GC:    cmd.op = OP_MUL_GC;
      S_TC:    cmd.op = OP_MUL_TC;
      S_LEVEL: cmd.op = OP_LEVEL;
      S_DIFF:  cmd.op = OP_DIFF;
      S_MUL_T: cmd.op = OP_MUL_T;
      S_SUM:   cmd.op = OP_SUM;
      S_FIN: begin
        if (out_free) begin
          cmd.op         = OP_FIN;
          out_valid_next = 1'b1;
        end
      end
      default: cmd.op = OP_NOP;
    endcase
  end

endmodule

FILE: hw/rtl/dxs_datapath.sv
// ----------------------------------------------------------------------------
// dxs_datapath
// config registers, level and slope state, one shared multiplier, accumulator
// ----------------------------------------------------------------------------
module dxs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dxs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [dxs_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              func,
  input  logic signed [dxs_pkg::DATA_W-1:0] sample,
  output logic signed [dxs_pkg::DATA_W-1:0] estimate,
  input  dxs_pkg::dp_cmd_t                  cmd,
  output dxs_pkg::dp_status_t               status
);
  import dxs_pkg::*;

  logic [GAIN_W-1:0]        est_gain;
  logic [GAIN_W-1:0]        trd_gain;
  logic [GAIN_W-1:0]        g;
  logic [GAIN_W-1:0]        t;
  logic signed [DATA_W-1:0] lvl;
  logic signed [DATA_W-1:0] slp;
  logic signed [DATA_W-1:0] smp;
  logic signed [DATA_W-1:0] nl;
  logic                     fn;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] acc;
  logic signed [GAIN_W:0]   mul_a;
  logic signed [OPB_W-1:0]  mul_b;

  // gains above one act as one
  assign g = (est_gain > GAIN_ONE) ? GAIN_ONE : est_gain;
  assign t = (trd_gain > GAIN_ONE) ? GAIN_ONE : trd_gain;

  assign status.load = fn;

  // multiplier operand select
  always_comb begin
    unique case (cmd.op)
      OP_MUL_G: begin
        mul_a = $signed({1'b0, g});
        mul_b = OPB_W'(smp);
      end
      OP_MUL_GC: begin
        mul_a = $signed({1'b0, GAIN_ONE - g});
        mul_b = opb;
      end
      OP_MUL_TC: begin
        mul_a = $signed({1'b0, GAIN_ONE - t});
        mul_b = OPB_W'(slp);
      end
      OP_MUL_T: begin
        mul_a = $signed({1'b0, t});
        mul_b = opb;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // config and state
  always_ff @(posedge clk) begin
    if (rst) begin
      est_gain <= GAIN_HALF;
      trd_gain <= GAIN_HALF;
      lvl      <= '0;
      slp      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ESTIMATE_GAIN:    est_gain <= cfg_data[GAIN_W-1:0];
        REG_TREND_GAIN:       trd_gain <= cfg_data[GAIN_W-1:0];
        REG_INITIAL_ESTIMATE: lvl      <= $signed(cfg_data);
        REG_INITIAL_TREND:    slp      <= $signed(cfg_data);
        default:              lvl      <= lvl;
      endcase
    end else if (cmd.op == OP_FIN) begin
      if (fn) begin
        lvl <= smp;
      end else begin
        lvl <= nl;
        slp <= round_sat(acc);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fn <= 1'b0;
    end else if (cmd.op == OP_TAKE) begin
      fn <= func;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_TAKE:   smp <= sample;
      OP_MUL_G: begin
        prod <= PROD_W'(mul_a * mul_b);
        opb  <= OPB_W'(lvl) + OPB_W'(slp);
      end
      OP_MUL_GC: begin
        prod <= PROD_W'(mul_a * mul_b);
        acc  <= prod;
      end
      OP_MUL_TC: begin
        prod <= PROD_W'(mul_a * mul_b);
        acc  <= acc + prod;
      end
      OP_LEVEL: begin
        nl  <= round_sat(acc);
        acc <= prod;
      end
      OP_DIFF:   opb  <= OPB_W'(nl) - OPB_W'(lvl);
      OP_MUL_T:  prod <= PROD_W'(mul_a * mul_b);
      OP_SUM:    acc  <= acc + prod;
      OP_FIN:    estimate <= fn ? smp : nl;
      default:   acc  <= acc;
    endcase
  end

endmodule

FILE: hw/rtl/double_exponential_smoother_top.sv
// a load word goes from start straight to write back; a smooth word runs the full sequence
// words are taken one at a time, a new one only after the last is written back, and
//   the single shared 18x34 multiplier forms the four products in turn
// the next word is accepted while the last result still waits in the output register
// reset (rst, synchronous, active high): gains 0.5, initial level and slope 0,
//   output empty
// ----------------------------------------------------------------------------
// double_exponential_smoother_top
// level and trend smoother, q16.16 data and q1.16 gains, 32-bit saturation
// ----------------------------------------------------------------------------
module double_exponential_smoother_top (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [dxs_pkg::IDX_W-1:0]         cfg_index,
  input  logic [dxs_pkg::DATA_W-1:0]        cfg_data,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic signed [dxs_pkg::DATA_W-1:0] sample,
  // result words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dxs_pkg::DATA_W-1:0] estimate
);
  import dxs_pkg::*;

  // controller drives one step code per cycle, datapath reports the word kind
  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer: idle, start, three products (two into the level sum, one
  // into the slope sum), round, level difference, fourth product, slope sum,
  // then write back and present; a load word goes from start straight to write back
  dxs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // level and slope state, config registers, multiplier and accumulator;
  // writes to the initial registers also load the state at once
  dxs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .func      (func),
    .sample    (sample),
    .estimate  (estimate),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: hw/rtl/dxs_checker.sv
// ----------------------------------------------------------------------------
// dxs_checker
// port-level checks of the smoother, bound to the top level
// ----------------------------------------------------------------------------
`include "double_exponential_smoother_top_assert.svh"

module dxs_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              func,
  input logic signed [dxs_pkg::DATA_W-1:0] sample,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [dxs_pkg::DATA_W-1:0] estimate
);

  // a stalled result word stays
  `DXS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // and keeps its value
  `DXS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(estimate))

  // one word in work at a time
  `DXS_ASSERT_NEXT(a_one_word, clk, rst, in_valid && in_ready, !in_ready)

  // a load word into an empty output shows its sample after start and write back
  `DXS_ASSERT_AFTER3(a_load_result, clk, rst,
    in_valid && in_ready && func && !out_valid,
    out_valid && (estimate == $past(sample, 3)))

endmodule

bind double_exponential_smoother_top dxs_checker u_checker (.*);
